FILE: rtl/core/bngt_pkg.sv
`default_nettype none
package bngt_pkg;

   localparam int unsigned NODE_ABITS = 16;
   localparam int unsigned LEAF_ABITS = 16;
   localparam int unsigned PROB_BITS = 16;
   localparam int unsigned BACKOFF_BITS = 14;
   localparam int unsigned MAX_ORDER = 4;
   localparam int unsigned WORD_BITS = 18;
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 18;

   localparam logic [31:0] Q_ONE = 32'h0100_0000;
   localparam logic [31:0] Q_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_QUERY = 3'd0,
      KIND_NODE  = 3'd1,
      KIND_LEAF  = 3'd2,
      KIND_PROB  = 3'd3,
      KIND_BOW   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_MODEL_ORDER = 3'd0,
      CSR_USE_LOG     = 3'd1,
      CSR_LEVEL1_BASE = 3'd2,
      CSR_LEVEL2_BASE = 3'd3,
      CSR_LEVEL3_BASE = 3'd4,
      CSR_FILLER_ID   = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_NA,
      ST_NB,
      ST_NT,
      ST_PROBE,
      ST_CMP,
      ST_MUL,
      ST_SAT,
      ST_BO_NEXT,
      ST_ROOT,
      ST_HA,
      ST_HL,
      ST_HB,
      ST_HC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [17:0] word_id;
      logic [2:0]  state_level;
      logic [17:0] state_index;
      logic [15:0] child_start;
      logic [15:0] pr_index;
      logic [13:0] bow_index;
      logic [31:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] cost;
      logic [2:0]  next_level;
      logic [15:0] next_index;
      logic [2:0]  hist_level;
      logic [15:0] hist_index;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]            model_order;
      logic                  use_log;
      logic [15:0]           level1_base;
      logic [15:0]           level2_base;
      logic [15:0]           level3_base;
      logic [WORD_BITS-1:0]  filler_id;
   } cfg_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] wid;
      logic [15:0]          ch;
      logic [PROB_BITS-1:0] pr;
   } node_key_type;

   typedef struct packed {
      logic [BACKOFF_BITS-1:0] bow;
      logic [2:0]              bol;
      logic [15:0]             bon;
   } node_link_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] wid;
      logic [PROB_BITS-1:0] pr;
      logic [2:0]           bol;
      logic [15:0]          bon;
   } leaf_type;

   typedef struct packed {
      logic [NODE_ABITS-1:0]   node_addr;
      logic [LEAF_ABITS-1:0]   leaf_addr;
      logic [PROB_BITS-1:0]    prob_addr;
      logic [BACKOFF_BITS-1:0] bow_addr;
   } rd_addr_type;

   typedef struct packed {
      node_key_type  key;
      node_link_type link;
      leaf_type      leaf;
      logic [31:0]   prob;
      logic [31:0]   bow;
   } rd_data_type;

   typedef struct packed {
      logic                    node_we;
      logic                    leaf_we;
      logic                    prob_we;
      logic                    bow_we;
      logic [NODE_ABITS-1:0]   node_addr;
      logic [LEAF_ABITS-1:0]   leaf_addr;
      logic [PROB_BITS-1:0]    prob_addr;
      logic [BACKOFF_BITS-1:0] bow_addr;
      node_key_type            key;
      node_link_type           link;
      leaf_type                leaf;
      logic [31:0]             value;
   } wr_type;

   function automatic logic [NODE_ABITS-1:0] node_addr(input cfg_type cfg,
                                                       input logic [2:0] lvl,
                                                       input logic [15:0] idx);
      logic [15:0] base;
      case (lvl)
         3'd1:    base = cfg.level1_base;
         3'd2:    base = cfg.level2_base;
         3'd3:    base = cfg.level3_base;
         default: base = 16'd0;
      endcase
      return NODE_ABITS'(base + idx);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bngt_store.sv
`default_nettype none
module bngt_store (
   input  wire                  clock,
   input  bngt_pkg::wr_type      wr,
   input  bngt_pkg::rd_addr_type rd_addr,
   output bngt_pkg::rd_data_type rd_data
);

   bngt_pkg::node_key_type  key_mem  [2**bngt_pkg::NODE_ABITS];
   bngt_pkg::node_link_type link_mem [2**bngt_pkg::NODE_ABITS];
   bngt_pkg::leaf_type      leaf_mem [2**bngt_pkg::LEAF_ABITS];
   logic [31:0]             prob_mem [2**bngt_pkg::PROB_BITS];
   logic [31:0]             bow_mem  [2**bngt_pkg::BACKOFF_BITS];

   always_ff @(posedge clock) begin
      if (wr.node_we) begin
         key_mem[wr.node_addr]  <= wr.key;
         link_mem[wr.node_addr] <= wr.link;
      end
      if (wr.leaf_we) begin
         leaf_mem[wr.leaf_addr] <= wr.leaf;
      end
      if (wr.prob_we) begin
         prob_mem[wr.prob_addr] <= wr.value;
      end
      if (wr.bow_we) begin
         bow_mem[wr.bow_addr] <= wr.value;
      end
      rd_data.key  <= key_mem[rd_addr.node_addr];
      rd_data.link <= link_mem[rd_addr.node_addr];
      rd_data.leaf <= leaf_mem[rd_addr.leaf_addr];
      rd_data.prob <= prob_mem[rd_addr.prob_addr];
      rd_data.bow  <= bow_mem[rd_addr.bow_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/bngt_walk.sv
`default_nettype none
module bngt_walk (
   input  wire                   clock,
   input  wire                   reset,
   input  bngt_pkg::cfg_type      cfg,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  bngt_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output bngt_pkg::rsp_item_type rsp_item,
   output bngt_pkg::rd_addr_type  rd_addr,
   input  bngt_pkg::rd_data_type  rd_data
);

   bngt_pkg::state_type state_ff, state_in, after_ff;

   logic [bngt_pkg::WORD_BITS-1:0] wid_ff;
   logic [2:0]                     slvl_ff, lvl_ff, rl_ff, hl_ff;
   logic [15:0]                    pos_ff, ri_ff, hi_ff;
   logic [15:0]                    h_ff, t_ff, m_ff, ch_a_ff;
   logic [bngt_pkg::BACKOFF_BITS-1:0] bow_ff;
   logic [2:0]                     bol_ff;
   logic [15:0]                    bon_ff;
   logic [bngt_pkg::PROB_BITS-1:0] pr_ff;
   logic                           src_bow_ff;
   logic [31:0]                    cost_ff;
   logic [63:0]                    prod_ff;
   logic                           rsp_valid_ff;
   bngt_pkg::rsp_item_type         rsp_ff;

   logic [2:0]  order;
   logic [2:0]  cl;
   logic        cl_leaf;
   logic [15:0] mid;
   logic [bngt_pkg::WORD_BITS-1:0] probe_wid;
   logic [bngt_pkg::PROB_BITS-1:0] probe_pr;
   logic [31:0] operand;
   logic [63:0] scaled;
   logic        accept;
   logic        out_free;

   always_comb begin
      if (cfg.model_order == 3'd0) begin
         order = 3'd1;
      end else if (cfg.model_order > 3'(bngt_pkg::MAX_ORDER)) begin
         order = 3'(bngt_pkg::MAX_ORDER);
      end else begin
         order = cfg.model_order;
      end
   end

   assign cl        = lvl_ff + 3'd1;
   assign cl_leaf   = (cl >= order);
   assign mid       = h_ff + ((t_ff - h_ff) >> 1);
   assign probe_wid = cl_leaf ? rd_data.leaf.wid : rd_data.key.wid;
   assign probe_pr  = cl_leaf ? rd_data.leaf.pr : rd_data.key.pr;
   assign operand   = src_bow_ff ? rd_data.bow : rd_data.prob;
   assign scaled    = cfg.use_log ? prod_ff : (prod_ff >> 24);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bngt_pkg::ST_IDLE: begin
            if (accept && req_item.kind == bngt_pkg::KIND_QUERY) state_in = bngt_pkg::ST_START;
         end
         bngt_pkg::ST_START: begin
            state_in = (wid_ff == cfg.filler_id) ? bngt_pkg::ST_HA : bngt_pkg::ST_NA;
         end
         bngt_pkg::ST_NA:    state_in = bngt_pkg::ST_NB;
         bngt_pkg::ST_NB:    state_in = bngt_pkg::ST_NT;
         bngt_pkg::ST_NT:    state_in = bngt_pkg::ST_PROBE;
         bngt_pkg::ST_PROBE: state_in = (h_ff < t_ff) ? bngt_pkg::ST_CMP : bngt_pkg::ST_MUL;
         bngt_pkg::ST_CMP: begin
            state_in = (probe_wid == wid_ff) ? bngt_pkg::ST_MUL : bngt_pkg::ST_PROBE;
         end
         bngt_pkg::ST_MUL:   state_in = bngt_pkg::ST_SAT;
         bngt_pkg::ST_SAT:   state_in = after_ff;
         bngt_pkg::ST_BO_NEXT: begin
            state_in = (lvl_ff == 3'd0) ? bngt_pkg::ST_ROOT : bngt_pkg::ST_NA;
         end
         bngt_pkg::ST_ROOT:  state_in = bngt_pkg::ST_MUL;
         bngt_pkg::ST_HA:    state_in = (rl_ff >= order) ? bngt_pkg::ST_HL : bngt_pkg::ST_HB;
         bngt_pkg::ST_HL:    state_in = bngt_pkg::ST_OUT;
         bngt_pkg::ST_HB:    state_in = bngt_pkg::ST_HC;
         bngt_pkg::ST_HC:    state_in = bngt_pkg::ST_OUT;
         bngt_pkg::ST_OUT:   state_in = out_free ? bngt_pkg::ST_IDLE : bngt_pkg::ST_OUT;
         default:            state_in = bngt_pkg::ST_IDLE;
      endcase
   end

   // outputs and memory read addresses
   always_comb begin
      req_stall = 1'b1;
      rd_addr   = '0;
      case (state_ff)
         bngt_pkg::ST_IDLE: req_stall = 1'b0;
         bngt_pkg::ST_NA: rd_addr.node_addr = bngt_pkg::node_addr(cfg, lvl_ff,
                                                        (lvl_ff == 3'd0) ? 16'd0 : pos_ff);
         bngt_pkg::ST_NB: rd_addr.node_addr = bngt_pkg::node_addr(cfg, lvl_ff,
                                                        (lvl_ff == 3'd0) ? 16'd0 : pos_ff) + 1'b1;
         bngt_pkg::ST_PROBE: begin
            rd_addr.node_addr = bngt_pkg::node_addr(cfg, cl, mid);
            rd_addr.leaf_addr = bngt_pkg::LEAF_ABITS'(mid);
            rd_addr.bow_addr  = bow_ff;
         end
         bngt_pkg::ST_CMP:  rd_addr.prob_addr = probe_pr;
         bngt_pkg::ST_MUL: begin
            rd_addr.prob_addr = pr_ff;
            rd_addr.bow_addr  = bow_ff;
         end
         bngt_pkg::ST_ROOT: rd_addr.prob_addr = rd_data.key.pr;
         bngt_pkg::ST_HA: begin
            rd_addr.node_addr = bngt_pkg::node_addr(cfg, rl_ff, ri_ff);
            rd_addr.leaf_addr = bngt_pkg::LEAF_ABITS'(ri_ff);
         end
         bngt_pkg::ST_HB: rd_addr.node_addr = bngt_pkg::node_addr(cfg, rl_ff, ri_ff) + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bngt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == bngt_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bngt_pkg::ST_IDLE: begin
            wid_ff  <= req_item.word_id;
            slvl_ff <= req_item.state_level;
            pos_ff  <= req_item.state_index[15:0];
            cost_ff <= cfg.use_log ? 32'd0 : bngt_pkg::Q_ONE;
            rl_ff   <= 3'd0;
            ri_ff   <= 16'd0;
         end
         bngt_pkg::ST_START: begin
            if (slvl_ff >= order) begin
               lvl_ff <= 3'd0;
               pos_ff <= 16'd0;
            end else begin
               lvl_ff <= slvl_ff;
            end
         end
         bngt_pkg::ST_NB: begin
            h_ff   <= rd_data.key.ch;
            bow_ff <= rd_data.link.bow;
            bol_ff <= rd_data.link.bol;
            bon_ff <= rd_data.link.bon;
         end
         bngt_pkg::ST_NT: t_ff <= rd_data.key.ch;
         bngt_pkg::ST_PROBE: begin
            m_ff <= mid;
            if (!(h_ff < t_ff)) begin
               src_bow_ff <= 1'b1;
               after_ff   <= bngt_pkg::ST_BO_NEXT;
            end
         end
         bngt_pkg::ST_CMP: begin
            if (probe_wid < wid_ff) begin
               h_ff <= m_ff + 16'd1;
            end else if (probe_wid > wid_ff) begin
               t_ff <= m_ff;
            end else begin
               rl_ff      <= cl;
               ri_ff      <= m_ff;
               pr_ff      <= probe_pr;
               src_bow_ff <= 1'b0;
               after_ff   <= bngt_pkg::ST_HA;
            end
         end
         bngt_pkg::ST_MUL: begin
            if (cfg.use_log) begin
               prod_ff <= 64'(cost_ff) + 64'(operand);
            end else begin
               prod_ff <= 64'(cost_ff) * 64'(operand);
            end
         end
         bngt_pkg::ST_SAT: cost_ff <= (|scaled[63:32]) ? bngt_pkg::Q_MAX : scaled[31:0];
         bngt_pkg::ST_BO_NEXT: begin
            if (bol_ff >= lvl_ff) begin
               lvl_ff <= 3'd0;
               pos_ff <= 16'd0;
            end else begin
               lvl_ff <= bol_ff;
               pos_ff <= bon_ff;
            end
         end
         bngt_pkg::ST_ROOT: begin
            pr_ff      <= rd_data.key.pr;
            rl_ff      <= 3'd0;
            ri_ff      <= 16'd0;
            src_bow_ff <= 1'b0;
            after_ff   <= bngt_pkg::ST_HA;
         end
         bngt_pkg::ST_HL: begin
            hl_ff <= rd_data.leaf.bol;
            hi_ff <= rd_data.leaf.bon;
         end
         bngt_pkg::ST_HB: begin
            ch_a_ff <= rd_data.key.ch;
            bol_ff  <= rd_data.link.bol;
            bon_ff  <= rd_data.link.bon;
         end
         bngt_pkg::ST_HC: begin
            // a node without children backs off to its link
            if (rd_data.key.ch == ch_a_ff) begin
               hl_ff <= bol_ff;
               hi_ff <= bon_ff;
            end else begin
               hl_ff <= rl_ff;
               hi_ff <= ri_ff;
            end
         end
         bngt_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_ff.cost       <= cost_ff;
               rsp_ff.next_level <= rl_ff;
               rsp_ff.next_index <= ri_ff;
               rsp_ff.hist_level <= hl_ff;
               rsp_ff.hist_index <= hi_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == bngt_pkg::ST_CMP |-> $past(h_ff) < $past(t_ff))
      else $error("probe issued on an empty range");

   a_sat_return: assert property (@(posedge clock) disable iff (reset)
      state_ff == bngt_pkg::ST_SAT |=> state_ff == $past(after_ff))
      else $error("combine did not return to its caller");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == bngt_pkg::ST_OUT)
      else $error("result raised outside the output state");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == bngt_pkg::ST_NA |-> lvl_ff < order)
      else $error("node level at or above model order");

endmodule
`default_nettype wire

FILE: rtl/core/backoff_ngram_transfer_top.sv
`default_nettype none
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | bngt_pkg::req_item_type
// rsp     | out       | rsp_valid/rsp_stall  | bngt_pkg::rsp_item_type
// csr     | in        | csr_we               | csr_index, csr_data
//
// Write items are stored as they transfer and do not stall req. A query stalls req
// from its transfer to hand-off: it starts, reads the node entries of each visited
// level, runs search probes, backs off on a miss, combines costs, falls back to the
// root if needed, then historifies a leaf or node and hands off. Reset is synchronous;
// it clears the sequencer and the output valid and sets the CSR defaults, while the
// stores keep their contents. A stalled result holds in the output register.
module backoff_ngram_transfer_top (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  bngt_pkg::req_item_type                   req_item,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output bngt_pkg::rsp_item_type                   rsp_item,
   input  wire                                     csr_we,
   input  wire [bngt_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  wire [bngt_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   bngt_pkg::cfg_type     cfg_ff;
   bngt_pkg::wr_type      wr;
   bngt_pkg::rd_addr_type rd_addr;
   bngt_pkg::rd_data_type rd_data;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.model_order <= 3'd3;
         cfg_ff.use_log     <= 1'b1;
         cfg_ff.level1_base <= 16'd0;
         cfg_ff.level2_base <= 16'd0;
         cfg_ff.level3_base <= 16'd0;
         cfg_ff.filler_id   <= bngt_pkg::WORD_BITS'(69);
      end else if (csr_we) begin
         case (csr_index)
            bngt_pkg::CSR_MODEL_ORDER: cfg_ff.model_order <= csr_data[2:0];
            bngt_pkg::CSR_USE_LOG:     cfg_ff.use_log     <= csr_data[0];
            bngt_pkg::CSR_LEVEL1_BASE: cfg_ff.level1_base <= csr_data[15:0];
            bngt_pkg::CSR_LEVEL2_BASE: cfg_ff.level2_base <= csr_data[15:0];
            bngt_pkg::CSR_LEVEL3_BASE: cfg_ff.level3_base <= csr_data[15:0];
            bngt_pkg::CSR_FILLER_ID:   cfg_ff.filler_id   <= csr_data[bngt_pkg::WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      wr.node_we   = accept && req_item.kind == bngt_pkg::KIND_NODE;
      wr.leaf_we   = accept && req_item.kind == bngt_pkg::KIND_LEAF;
      wr.prob_we   = accept && req_item.kind == bngt_pkg::KIND_PROB;
      wr.bow_we    = accept && req_item.kind == bngt_pkg::KIND_BOW;
      wr.node_addr = req_item.address;
      wr.leaf_addr = req_item.address;
      wr.prob_addr = req_item.address[bngt_pkg::PROB_BITS-1:0];
      wr.bow_addr  = req_item.address[bngt_pkg::BACKOFF_BITS-1:0];
      wr.key.wid   = req_item.word_id;
      wr.key.ch    = req_item.child_start;
      wr.key.pr    = req_item.pr_index;
      wr.link.bow  = req_item.bow_index;
      wr.link.bol  = req_item.state_level;
      wr.link.bon  = req_item.state_index[15:0];
      wr.leaf.wid  = req_item.word_id;
      wr.leaf.pr   = req_item.pr_index;
      wr.leaf.bol  = req_item.state_level;
      wr.leaf.bon  = req_item.state_index[15:0];
      wr.value     = req_item.table_value;
   end

   bngt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bngt_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

endmodule
`default_nettype wire
